>>> rtl/core/ffp_pkg.sv
// shared types, codes and helpers of the flagged frame parser
package ffp_pkg;

  // result item kinds
  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // summary status codes
  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_CORRECT    = 2'd1;
  localparam logic [1:0] ST_INCORRECT  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN    = 2'd3;

  // unit event commands
  localparam logic [7:0] CMD_STATE  = 8'h0c;
  localparam logic [7:0] CMD_PLAIN  = 8'h0d;
  localparam logic [7:0] CMD_CHANGE = 8'h00;

  localparam logic [8:0] NO_EVENT   = 9'h1ff;
  localparam logic [5:0] TEXT_SHORT = 6'd16;
  localparam logic [5:0] TEXT_LONG  = 6'd32;

  // data bytes kept for event decoding
  localparam int EVB_DEPTH = 5;
  // result queue depth
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [62:0] device_number;
    logic [62:0] flag_word;
    logic [5:0]  text_length;
    logic [6:0]  data_length;
    logic [8:0]  event_code;
    logic [7:0]  unit_number;
    logic [7:0]  unit_type;
    logic [7:0]  unit_state;
    logic [7:0]  unit_prev_state;
  } ffp_res_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] cnt;
    ffp_res_t   first;
    ffp_res_t   second;
  } ffp_push_t;

  // text length from flag bits 4 and 3
  function automatic logic [5:0] text_len(input logic [1:0] b43);
    logic [5:0] len;
    case (b43)
      2'b10:   len = TEXT_SHORT;
      2'b01:   len = TEXT_LONG;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/ffp_parse.sv
// frame field tracking, checksum, echo and summary generation
module ffp_parse #(
  parameter int MAX_VARINT_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        frame_byte,
  input  logic              last,
  output ffp_pkg::ffp_push_t push
);

  localparam int CntW    = $clog2(MAX_VARINT_BYTES + 1);
  localparam int EvbIdxW = $clog2(ffp_pkg::EVB_DEPTH);

  typedef enum logic [2:0] {
    PH_DEV, PH_FLG, PH_TXT, PH_LEN, PH_DAT, PH_CRC, PH_END
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [62:0]     accum_r, accum_nxt;
  logic [CntW-1:0] vcnt_r, vcnt_nxt;
  logic [62:0]     dev_r, dev_nxt;
  logic [62:0]     flag_r, flag_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic [6:0]      dlen_r, dlen_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic            err_r, err_nxt;
  logic [7:0]      evb_r   [ffp_pkg::EVB_DEPTH];
  logic [7:0]      evb_nxt [ffp_pkg::EVB_DEPTH];

  logic [5:0]       sh;
  logic [62:0]      acc_add;
  logic             echo;
  ffp_pkg::ffp_res_t echo_res, summ_res;

  // groups never overlap below bit 63, so or-ing equals the add
  assign sh      = 6'(7 * vcnt_r);
  assign acc_add = accum_r | (63'(frame_byte[6:0]) << sh);

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    vcnt_nxt  = vcnt_r;
    dev_nxt   = dev_r;
    flag_nxt  = flag_r;
    cnt_nxt   = cnt_r;
    dlen_nxt  = dlen_r;
    sum_nxt   = sum_r;
    err_nxt   = err_r;
    evb_nxt   = evb_r;
    echo      = 1'b0;
    echo_res              = '0;
    echo_res.payload_byte = frame_byte;
    echo_res.event_code   = ffp_pkg::NO_EVENT;

    if (acc && !err_r) begin
      sum_nxt = sum_r + frame_byte;
      case (phase_r)
        PH_DEV, PH_FLG: begin
          if (frame_byte[7]) begin
            accum_nxt = acc_add;
            vcnt_nxt  = vcnt_r + 1'b1;
            if (vcnt_nxt >= CntW'(MAX_VARINT_BYTES)) err_nxt = 1'b1;
          end else begin
            accum_nxt = '0;
            vcnt_nxt  = '0;
            if (phase_r == PH_DEV) begin
              dev_nxt   = acc_add;
              phase_nxt = PH_FLG;
            end else begin
              flag_nxt = acc_add;
              cnt_nxt  = '0;
              if (ffp_pkg::text_len(acc_add[4:3]) != 6'd0) phase_nxt = PH_TXT;
              else if (acc_add[2]) phase_nxt = PH_LEN;
              else phase_nxt = PH_CRC;
            end
          end
        end
        PH_TXT: begin
          echo          = 1'b1;
          echo_res.kind = ffp_pkg::KIND_TEXT;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_nxt >= 7'(ffp_pkg::text_len(flag_r[4:3]))) begin
            cnt_nxt   = '0;
            phase_nxt = flag_r[2] ? PH_LEN : PH_CRC;
          end
        end
        PH_LEN: begin
          if (frame_byte[7]) begin
            err_nxt = 1'b1;
          end else begin
            dlen_nxt  = frame_byte[6:0];
            cnt_nxt   = '0;
            phase_nxt = (frame_byte == 8'd0) ? PH_CRC : PH_DAT;
          end
        end
        PH_DAT: begin
          echo          = 1'b1;
          echo_res.kind = ffp_pkg::KIND_DATA;
          if (cnt_r < 7'(ffp_pkg::EVB_DEPTH)) evb_nxt[cnt_r[EvbIdxW-1:0]] = frame_byte;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt >= dlen_r) phase_nxt = PH_CRC;
        end
        PH_CRC: begin
          phase_nxt = PH_END;
        end
        default: begin
          // byte after the checksum
          err_nxt = 1'b1;
        end
      endcase
    end

    // summary sees the state after this byte
    summ_res               = '0;
    summ_res.kind          = ffp_pkg::KIND_SUMMARY;
    summ_res.event_code    = ffp_pkg::NO_EVENT;
    summ_res.device_number = dev_nxt;
    summ_res.flag_word     = flag_nxt;
    summ_res.data_length   = dlen_nxt;
    summ_res.text_length   = (phase_nxt >= PH_TXT) ? ffp_pkg::text_len(flag_nxt[4:3]) : 6'd0;
    if (err_nxt) begin
      summ_res.status = ffp_pkg::ST_INCORRECT;
    end else if (phase_nxt != PH_END) begin
      summ_res.status = ffp_pkg::ST_INCOMPLETE;
    end else if (sum_nxt != 8'd0) begin
      summ_res.status = ffp_pkg::ST_INCORRECT;
    end else begin
      summ_res.status = ffp_pkg::ST_CORRECT;
      if (flag_nxt[2:1] == 2'b11 && dlen_nxt >= 7'd3) begin
        summ_res.event_code = {1'b0, evb_nxt[2]};
        if (evb_nxt[2] == ffp_pkg::CMD_STATE && dlen_nxt == 7'd4) begin
          summ_res.unit_number = evb_nxt[0];
          summ_res.unit_type   = evb_nxt[1];
          summ_res.unit_state  = evb_nxt[3];
        end else if (evb_nxt[2] == ffp_pkg::CMD_PLAIN && dlen_nxt == 7'd3) begin
          summ_res.unit_number = evb_nxt[0];
        end else if (evb_nxt[2] == ffp_pkg::CMD_CHANGE && dlen_nxt == 7'd5) begin
          summ_res.unit_number     = evb_nxt[0];
          summ_res.unit_type       = evb_nxt[1];
          summ_res.unit_state      = evb_nxt[3];
          summ_res.unit_prev_state = evb_nxt[4];
        end else begin
          summ_res.status = ffp_pkg::ST_UNKNOWN;
        end
      end
    end

    push        = '0;
    push.first  = echo ? echo_res : summ_res;
    push.second = summ_res;
    if (acc) push.cnt = {1'b0, echo} + {1'b0, last};

    // frame restarts after its summary
    if (acc && last) begin
      phase_nxt = PH_DEV;
      accum_nxt = '0;
      vcnt_nxt  = '0;
      dev_nxt   = '0;
      flag_nxt  = '0;
      cnt_nxt   = '0;
      dlen_nxt  = '0;
      sum_nxt   = '0;
      err_nxt   = 1'b0;
      for (int i = 0; i < ffp_pkg::EVB_DEPTH; i++) evb_nxt[i] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DEV;
      accum_r <= '0;
      vcnt_r  <= '0;
      dev_r   <= '0;
      flag_r  <= '0;
      cnt_r   <= '0;
      dlen_r  <= '0;
      sum_r   <= '0;
      err_r   <= 1'b0;
      for (int i = 0; i < ffp_pkg::EVB_DEPTH; i++) evb_r[i] <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      vcnt_r  <= vcnt_nxt;
      dev_r   <= dev_nxt;
      flag_r  <= flag_nxt;
      cnt_r   <= cnt_nxt;
      dlen_r  <= dlen_nxt;
      sum_r   <= sum_nxt;
      err_r   <= err_nxt;
      evb_r   <= evb_nxt;
    end
  end

endmodule

>>> rtl/core/ffp_res_fifo.sv
// result queue taking up to two items per cycle and giving one per cycle when popped
module ffp_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  ffp_pkg::ffp_push_t push,
  input  logic               pop,
  output logic               not_empty,
  output logic               no_room,
  output ffp_pkg::ffp_res_t  head
);

  localparam int PtrW = $clog2(ffp_pkg::RES_DEPTH);
  localparam int LvlW = $clog2(ffp_pkg::RES_DEPTH + 1);

  ffp_pkg::ffp_res_t ent_r [ffp_pkg::RES_DEPTH];
  logic [PtrW-1:0]   wr_r, rd_r;
  logic [LvlW-1:0]   lvl_r;
  logic [PtrW-1:0]   wr_next_slot;

  assign wr_next_slot = wr_r + 1'b1;
  assign not_empty    = (lvl_r != '0);
  // room for two results is needed before an item may enter
  assign no_room      = (lvl_r > LvlW'(ffp_pkg::RES_DEPTH - 2));
  assign head         = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) ent_r[wr_r] <= push.first;
    if (push.cnt == 2'd2) ent_r[wr_next_slot] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      wr_r  <= wr_r + PtrW'(push.cnt);
      rd_r  <= rd_r + PtrW'(pop);
      lvl_r <= lvl_r + LvlW'(push.cnt) - LvlW'(pop);
    end
  end

endmodule

>>> rtl/core/flagged_frame_parser.sv
// top level of the flagged frame parser
//
//  channel | ports                          | direction | one item is
//  --------+--------------------------------+-----------+------------------------------
//  in      | in_valid in_stall in_frame_byte | sink      | one frame byte, end marker
//          | in_end_of_buffer               |           |
//  out     | out_valid out_stall out_*      | source    | echoed text/data byte or summary
//
// one byte is taken per cycle while in_stall is low; its field update, checksum add and any echo and
// summary are formed in the same cycle and written into a four-entry result queue
// results leave one per cycle while out_stall is low, so a byte that yields echo and summary
// gives the output side two items to send; the queue absorbs that
// in_stall rises whenever fewer than two queue entries are free
// rst_n is synchronous and active low; it empties the queue and starts a new frame
module flagged_frame_parser #(
  parameter int MAX_VARINT_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_end_of_buffer,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_payload_byte,
  output logic [1:0]        out_status,
  output logic [62:0]       out_device_number,
  output logic [62:0]       out_flag_word,
  output logic [5:0]        out_text_length,
  output logic [6:0]        out_data_length,
  output logic signed [8:0] out_event_code,
  output logic [7:0]        out_unit_number,
  output logic [7:0]        out_unit_type,
  output logic [7:0]        out_unit_state,
  output logic [7:0]        out_unit_prev_state
);

  logic               in_acc;
  logic               out_pop;
  logic               no_room;
  ffp_pkg::ffp_push_t push;
  ffp_pkg::ffp_res_t  head;

  // an item enters only when the queue can take both possible results
  assign in_stall = no_room;
  assign in_acc   = in_valid && !no_room;
  assign out_pop  = out_valid && !out_stall;

  // parser: field phases, varint assembly, checksum, event capture
  ffp_parse #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .frame_byte (in_frame_byte),
    .last       (in_end_of_buffer),
    .push       (push)
  );

  // result queue, decouples the two sides
  ffp_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_pop),
    .not_empty (out_valid),
    .no_room   (no_room),
    .head      (head)
  );

  // unpack the head item onto the field ports
  assign out_kind            = head.kind;
  assign out_payload_byte    = head.payload_byte;
  assign out_status          = head.status;
  assign out_device_number   = head.device_number;
  assign out_flag_word       = head.flag_word;
  assign out_text_length     = head.text_length;
  assign out_data_length     = head.data_length;
  assign out_event_code      = head.event_code;
  assign out_unit_number     = head.unit_number;
  assign out_unit_type       = head.unit_type;
  assign out_unit_state      = head.unit_state;
  assign out_unit_prev_state = head.unit_prev_state;

endmodule

>>> rtl/core/ffp_checker.sv
// port level checks of the flagged frame parser and their bind
module ffp_port_checks (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_kind,
  input logic [7:0]        out_payload_byte,
  input logic [1:0]        out_status,
  input logic [62:0]       out_device_number,
  input logic [62:0]       out_flag_word,
  input logic [5:0]        out_text_length,
  input logic [6:0]        out_data_length,
  input logic signed [8:0] out_event_code,
  input logic [7:0]        out_unit_number,
  input logic [7:0]        out_unit_type,
  input logic [7:0]        out_unit_state,
  input logic [7:0]        out_unit_prev_state
);

  // queue is empty and open right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("result item present after reset");

  // a stalled result item stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_payload_byte)
      && $stable(out_status) && $stable(out_device_number) && $stable(out_flag_word)
      && $stable(out_text_length) && $stable(out_data_length) && $stable(out_event_code)
      && $stable(out_unit_number) && $stable(out_unit_type) && $stable(out_unit_state)
      && $stable(out_unit_prev_state))
    else $error("stalled result item changed");

  // echo items carry no summary content
  a_echo_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != ffp_pkg::KIND_SUMMARY |->
      out_event_code == -9'sd1 && out_status == ffp_pkg::ST_INCOMPLETE
      && out_device_number == 63'd0 && out_kind != 2'd3)
    else $error("echo item with summary fields");

  // only a checked frame can report an event
  a_event_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ffp_pkg::KIND_SUMMARY
      && (out_status == ffp_pkg::ST_INCOMPLETE || out_status == ffp_pkg::ST_INCORRECT) |->
      out_event_code == -9'sd1 && out_unit_number == 8'd0 && out_unit_type == 8'd0
      && out_unit_state == 8'd0 && out_unit_prev_state == 8'd0)
    else $error("event reported on a frame that failed");

endmodule

bind flagged_frame_parser ffp_port_checks u_port_checks (.*);

>>> tb/sv/ffp_checker.sv
// checker for the flagged frame parser: predicts each result item and compares it
module ffp_checker #(
  parameter int MAX_VARINT_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_end_of_buffer,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_kind,
  input  logic [7:0]        out_payload_byte,
  input  logic [1:0]        out_status,
  input  logic [62:0]       out_device_number,
  input  logic [62:0]       out_flag_word,
  input  logic [5:0]        out_text_length,
  input  logic [6:0]        out_data_length,
  input  logic signed [8:0] out_event_code,
  input  logic [7:0]        out_unit_number,
  input  logic [7:0]        out_unit_type,
  input  logic [7:0]        out_unit_state,
  input  logic [7:0]        out_unit_prev_state,
  output int                fail_count,
  output int                pending,
  output int                results_checked,
  output int                n_correct,
  output int                n_incorrect,
  output int                n_incomplete,
  output int                n_unknown
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 100;

  typedef enum logic [2:0] {
    FLD_DEVICE, FLD_FLAGS, FLD_TEXT, FLD_LENGTH, FLD_DATA, FLD_CHECKSUM, FLD_DONE
  } field_t;

  // predicted parser state
  field_t      field;
  logic [63:0] vint_acc;
  logic [3:0]  vint_cnt;
  logic [63:0] dev_r;
  logic [63:0] flags_r;
  logic [7:0]  pos_r;
  logic [7:0]  dlen_r;
  logic [7:0]  sum_r;
  logic        broken_r;
  logic [7:0]  unit_bytes [ffp_pkg::EVB_DEPTH];

  ffp_pkg::ffp_res_t expected_items [$];
  ffp_pkg::ffp_res_t got, want;

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    n_correct       = 0;
    n_incorrect     = 0;
    n_incomplete    = 0;
    n_unknown       = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED)
      $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] g, input logic [63:0] w);
    if (g !== w)
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                results_checked, name, g, w));
  endtask

  function automatic logic [5:0] text_bytes(input logic [63:0] f);
    logic [5:0] n;
    case ({f[4], f[3]})
      2'b10:   n = ffp_pkg::TEXT_SHORT;
      2'b01:   n = ffp_pkg::TEXT_LONG;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  task automatic restart_frame();
    field    = FLD_DEVICE;
    vint_acc = '0;
    vint_cnt = '0;
    dev_r    = '0;
    flags_r  = '0;
    pos_r    = '0;
    dlen_r   = '0;
    sum_r    = '0;
    broken_r = 1'b0;
    foreach (unit_bytes[i]) unit_bytes[i] = '0;
  endtask

  // one 7-bit group; returns 1 when the varint is complete
  function automatic bit varint_group(input logic [7:0] b);
    int sh;
    sh = (7 * vint_cnt) & 63;
    vint_acc = vint_acc + ({57'd0, b[6:0]} << sh);
    if (b[7]) begin
      vint_cnt++;
      if (vint_cnt >= MAX_VARINT_BYTES) broken_r = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ffp_pkg::ffp_res_t echo_item(input logic [1:0] kind, input logic [7:0] b);
    ffp_pkg::ffp_res_t r;
    r = '0;
    r.kind         = kind;
    r.payload_byte = b;
    r.event_code   = ffp_pkg::NO_EVENT;
    return r;
  endfunction

  function automatic ffp_pkg::ffp_res_t summary_item();
    ffp_pkg::ffp_res_t r;
    r = '0;
    r.kind       = ffp_pkg::KIND_SUMMARY;
    r.event_code = ffp_pkg::NO_EVENT;
    if (broken_r) r.status = ffp_pkg::ST_INCORRECT;
    else if (field != FLD_DONE) r.status = ffp_pkg::ST_INCOMPLETE;
    else if (sum_r != 8'd0) r.status = ffp_pkg::ST_INCORRECT;
    else begin
      r.status = ffp_pkg::ST_CORRECT;
      if (flags_r[2:1] == 2'b11 && dlen_r >= 8'd3) begin
        r.event_code = {1'b0, unit_bytes[2]};
        if (unit_bytes[2] == ffp_pkg::CMD_STATE && dlen_r == 8'd4) begin
          r.unit_number = unit_bytes[0];
          r.unit_type   = unit_bytes[1];
          r.unit_state  = unit_bytes[3];
        end else if (unit_bytes[2] == ffp_pkg::CMD_PLAIN && dlen_r == 8'd3) begin
          r.unit_number = unit_bytes[0];
        end else if (unit_bytes[2] == ffp_pkg::CMD_CHANGE && dlen_r == 8'd5) begin
          r.unit_number     = unit_bytes[0];
          r.unit_type       = unit_bytes[1];
          r.unit_state      = unit_bytes[3];
          r.unit_prev_state = unit_bytes[4];
        end else begin
          r.status = ffp_pkg::ST_UNKNOWN;
        end
      end
    end
    r.device_number = dev_r[62:0];
    r.flag_word     = flags_r[62:0];
    r.text_length   = (field >= FLD_TEXT) ? text_bytes(flags_r) : 6'd0;
    r.data_length   = dlen_r[6:0];
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last);
    ffp_pkg::ffp_res_t s;
    if (!broken_r) begin
      sum_r = sum_r + b;
      case (field)
        FLD_DEVICE: begin
          if (varint_group(b)) begin
            dev_r    = vint_acc;
            vint_acc = '0;
            vint_cnt = '0;
            field    = FLD_FLAGS;
          end
        end
        FLD_FLAGS: begin
          if (varint_group(b)) begin
            flags_r  = vint_acc;
            vint_acc = '0;
            vint_cnt = '0;
            pos_r    = '0;
            if (text_bytes(flags_r) != 6'd0) field = FLD_TEXT;
            else if (flags_r[2]) field = FLD_LENGTH;
            else field = FLD_CHECKSUM;
          end
        end
        FLD_TEXT: begin
          expected_items.push_back(echo_item(ffp_pkg::KIND_TEXT, b));
          pos_r++;
          if (pos_r >= {2'b00, text_bytes(flags_r)}) begin
            pos_r = '0;
            field = flags_r[2] ? FLD_LENGTH : FLD_CHECKSUM;
          end
        end
        FLD_LENGTH: begin
          if (b[7]) broken_r = 1'b1;
          else begin
            dlen_r = b;
            pos_r  = '0;
            field  = (b == 8'd0) ? FLD_CHECKSUM : FLD_DATA;
          end
        end
        FLD_DATA: begin
          expected_items.push_back(echo_item(ffp_pkg::KIND_DATA, b));
          if (pos_r < ffp_pkg::EVB_DEPTH) unit_bytes[pos_r] = b;
          pos_r++;
          if (pos_r >= dlen_r) field = FLD_CHECKSUM;
        end
        FLD_CHECKSUM: field = FLD_DONE;
        default: broken_r = 1'b1;
      endcase
    end
    if (last) begin
      s = summary_item();
      expected_items.push_back(s);
      case (s.status)
        ffp_pkg::ST_CORRECT:    n_correct++;
        ffp_pkg::ST_INCORRECT:  n_incorrect++;
        ffp_pkg::ST_INCOMPLETE: n_incomplete++;
        default:                n_unknown++;
      endcase
      restart_frame();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_frame();
      expected_items.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind            = out_kind;
        got.payload_byte    = out_payload_byte;
        got.status          = out_status;
        got.device_number   = out_device_number;
        got.flag_word       = out_flag_word;
        got.text_length     = out_text_length;
        got.data_length     = out_data_length;
        got.event_code      = out_event_code;
        got.unit_number     = out_unit_number;
        got.unit_type       = out_unit_type;
        got.unit_state      = out_unit_state;
        got.unit_prev_state = out_unit_prev_state;
        if (expected_items.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with nothing predicted", out_kind));
        end else begin
          want = expected_items.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("payload_byte", got.payload_byte, want.payload_byte);
          check_field("status", got.status, want.status);
          check_field("device_number", got.device_number, want.device_number);
          check_field("flag_word", got.flag_word, want.flag_word);
          check_field("text_length", got.text_length, want.text_length);
          check_field("data_length", got.data_length, want.data_length);
          check_field("event_code", got.event_code, want.event_code);
          check_field("unit_number", got.unit_number, want.unit_number);
          check_field("unit_type", got.unit_type, want.unit_type);
          check_field("unit_state", got.unit_state, want.unit_state);
          check_field("unit_prev_state", got.unit_prev_state, want.unit_prev_state);
          results_checked++;
        end
      end
      if (in_valid && !in_stall) predict_byte(in_frame_byte, in_end_of_buffer);
      pending <= expected_items.size();
    end
  end

endmodule

>>> tb/sv/tb_flagged_frame_parser.sv
// testbench top for the flagged frame parser: frame stimulus, stall pattern and verdict
module tb_flagged_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXV           = 9;
  localparam int RANDOM_BYTES   = 850;
  // cycles with no item moving on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 1000;
  // settling time after the last expected result
  localparam int TAIL_CYCLES    = 20;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_frame_byte;
  logic              in_end_of_buffer;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_kind;
  logic [7:0]        out_payload_byte;
  logic [1:0]        out_status;
  logic [62:0]       out_device_number;
  logic [62:0]       out_flag_word;
  logic [5:0]        out_text_length;
  logic [6:0]        out_data_length;
  logic signed [8:0] out_event_code;
  logic [7:0]        out_unit_number;
  logic [7:0]        out_unit_type;
  logic [7:0]        out_unit_state;
  logic [7:0]        out_unit_prev_state;

  int fail_count, pending, results_checked;
  int n_correct, n_incorrect, n_incomplete, n_unknown;

  // bytes of the frame about to be sent
  logic [7:0] frame_q [$];
  int bytes_sent;
  int frames_sent;
  int quiet_cycles;

  flagged_frame_parser #(.MAX_VARINT_BYTES(MAXV)) uut (.*);

  ffp_checker #(.MAX_VARINT_BYTES(MAXV)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a run where nothing moves for too long has hung
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver stall pattern: free-running stretches, short flicker, the odd long hold
  initial begin
    int r, n;
    logic s;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        s = 1'b0;
        n = $urandom_range(5, 40);
      end else if (r < 90) begin
        s = 1'($urandom_range(0, 1));
        n = $urandom_range(1, 3);
      end else begin
        s = 1'b1;
        n = $urandom_range(8, 40);
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= s;
      end
    end
  end

  // sender gap: mostly none, often short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid low, with junk on the payload that must be ignored; n sets the length of the gap
  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_frame_byte    <= 8'($urandom);
      in_end_of_buffer <= 1'($urandom);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_frame_byte    <= b;
    in_end_of_buffer <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // hold off until every predicted result has been delivered
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // sends frame_q, marking its final byte as end of buffer
  task automatic send_frame(input bit with_gaps);
    foreach (frame_q[i]) begin
      if (with_gaps) idle(gap_len());
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    frames_sent++;
  endtask

  // n varint groups, low group given, the rest random
  task automatic push_groups(input int n, input logic [6:0] low);
    logic [6:0] g;
    for (int i = 0; i < n; i++) begin
      g = (i == 0) ? low : 7'($urandom);
      frame_q.push_back({i != n - 1, g});
    end
  endtask

  // appends the byte that brings the frame sum to zero
  task automatic seal_frame();
    logic [7:0] s;
    s = 8'd0;
    foreach (frame_q[i]) s = s + frame_q[i];
    frame_q.push_back(8'(~s + 8'd1));
  endtask

  task automatic build_random_frame();
    int shape, ndev, nflg, tl, dl, cut, r;
    logic [6:0] fl;
    logic [7:0] cmd, b;
    bit use_cmd;
    frame_q.delete();
    shape = $urandom_range(0, 99);
    // plain noise, no frame structure at all
    if (shape < 4) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      return;
    end
    // device number: usually short, sometimes long, at or past the group limit when asked
    if (shape < 7) ndev = MAXV + $urandom_range(0, 1);
    else if ($urandom_range(0, 9) == 0) ndev = $urandom_range(3, MAXV);
    else ndev = $urandom_range(1, 2);
    push_groups(ndev, 7'($urandom));
    // flag word: text bits at random, data and event bits biased towards set
    fl    = 7'($urandom);
    fl[2] = ($urandom_range(0, 99) < 60);
    fl[1] = ($urandom_range(0, 99) < 60);
    if (shape >= 10 && shape < 13) fl[2] = 1'b1;
    if (shape >= 7 && shape < 10) nflg = MAXV + $urandom_range(0, 1);
    else if ($urandom_range(0, 9) == 0) nflg = $urandom_range(2, MAXV);
    else nflg = 1;
    push_groups(nflg, fl);
    // text block
    case (fl[4:3])
      2'b10:   tl = 16;
      2'b01:   tl = 32;
      default: tl = 0;
    endcase
    repeat (tl) frame_q.push_back(8'($urandom));
    // data block, sized mostly around the unit event lengths, or a length byte with its top bit set
    if (fl[2]) begin
      if (shape >= 10 && shape < 13) begin
        frame_q.push_back(8'($urandom_range(128, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) dl = $urandom_range(3, 5);
        else if (r < 90) dl = $urandom_range(0, 8);
        else if (r < 97) dl = $urandom_range(9, 40);
        else dl = $urandom_range(41, 127);
        frame_q.push_back(8'(dl));
        use_cmd = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 3))
          0:       cmd = ffp_pkg::CMD_STATE;
          1:       cmd = ffp_pkg::CMD_PLAIN;
          2:       cmd = ffp_pkg::CMD_CHANGE;
          default: cmd = 8'($urandom);
        endcase
        for (int i = 0; i < dl; i++) begin
          b = (i == 2 && use_cmd) ? cmd : 8'($urandom);
          frame_q.push_back(b);
        end
      end
    end
    seal_frame();
    // damaged frames: bad checksum, cut short, or trailing bytes
    if (shape >= 13 && shape < 19) begin
      frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'($urandom_range(1, 255));
    end else if (shape >= 19 && shape < 27) begin
      if ($urandom_range(0, 2) == 0) cut = frame_q.size() - 1;
      else cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end else if (shape >= 27 && shape < 32) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_frame_byte    = 8'd0;
    in_end_of_buffer = 1'b0;
    bytes_sent       = 0;
    frames_sent      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smallest correct frame: device 0, no flags, checksum
    frame_q = '{8'h00, 8'h00};
    seal_frame();
    send_frame(1'b0);
    // largest device number in nine groups
    frame_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00};
    seal_frame();
    send_frame(1'b0);
    // overlong varint: still continuing at the last allowed group
    frame_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_frame(1'b0);
    // length byte with its top bit set
    frame_q = '{8'h01, 8'h04, 8'h80};
    send_frame(1'b0);
    // unit event without state, three data bytes
    frame_q = '{8'h02, 8'h06, 8'h03, 8'h05, 8'h07, ffp_pkg::CMD_PLAIN};
    seal_frame();
    send_frame(1'b1);
    wait_for_drain();

    // random frames, mostly well formed, with a drain pause now and then
    while (bytes_sent < RANDOM_BYTES) begin
      build_random_frame();
      send_frame($urandom_range(0, 3) != 0);
      if (frames_sent % 15 == 0) wait_for_drain();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // let the queue empty, then give any stray result time to show up
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d bytes in %0d frames, %0d result items checked",
             bytes_sent, frames_sent, results_checked);
    $display("summaries: %0d correct, %0d incorrect, %0d incomplete, %0d unknown event",
             n_correct, n_incorrect, n_incomplete, n_unknown);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ffp_pkg.sv
rtl/core/ffp_parse.sv
rtl/core/ffp_res_fifo.sv
rtl/core/flagged_frame_parser.sv
rtl/core/ffp_checker.sv
tb/sv/ffp_checker.sv
tb/sv/tb_flagged_frame_parser.sv
